// ----- design/ippmac_pkg.sv -----
// Shared types and constants for the IP to pseudo-MAC resolution table.
package ippmac_pkg;

    // Item kinds carried on the input side.
    localparam logic [1:0] KIND_REGISTER = 2'd0;
    localparam logic [1:0] KIND_ARP      = 2'd1;

    // Result status codes.
    localparam logic [2:0] STAT_REGISTERED = 3'd0;
    localparam logic [2:0] STAT_HIT        = 3'd1;
    localparam logic [2:0] STAT_MISS       = 3'd2;
    localparam logic [2:0] STAT_UNKNOWN    = 3'd3;
    localparam logic [2:0] STAT_FULL       = 3'd4;

    // Field widths.
    localparam int IP_W   = 32;
    localparam int PMAC_W = 48;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;

    // Broadcast pseudo MAC returned on a lookup miss.
    localparam logic [PMAC_W-1:0] BCAST_PMAC = 48'hFFFF_FFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // load the input transaction and rewind the scan
        logic scan;    // issue one table read and compare the previous one
        logic finish;  // build the result and update the table
    } ippmac_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // match found, table exhausted, nothing to scan, or unknown kind
        logic out_free;   // result register can take a new result this cycle
    } ippmac_sts_t;

endpackage

// ----- design/ippmac_ctrl.sv -----
// Controller state machine that sequences accept, table scan and result hand-off.
module ippmac_ctrl import ippmac_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ippmac_sts_t sts,
    output ippmac_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ippmac_datapath.sv -----
// Datapath: table memories, fill count, sequential lookup scan and result register.
module ippmac_datapath import ippmac_pkg::*; #(
    parameter int TABLE_DEPTH    = 64,
    parameter int SWITCH_ID_BITS = 6,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = AW + 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ippmac_cmd_t               cmd,
    output ippmac_sts_t               sts,
    // Input transaction fields.
    input  logic [KIND_W-1:0]         in_kind,
    input  logic [IP_W-1:0]           in_host_ip,
    input  logic [PMAC_W-1:0]         in_pmac,
    input  logic [IP_W-1:0]           in_src_ip,
    input  logic [PMAC_W-1:0]         in_src_pmac,
    input  logic [SWITCH_ID_BITS-1:0] in_from_switch,
    // Result transaction.
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [STAT_W-1:0]         out_status,
    output logic [IP_W-1:0]           out_src_ip,
    output logic [PMAC_W-1:0]         out_src_pmac,
    output logic [IP_W-1:0]           out_dest_ip,
    output logic [PMAC_W-1:0]         out_dest_pmac,
    output logic                      out_flood,
    output logic [SWITCH_ID_BITS-1:0] out_exclude
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Table storage; valid entries are exactly the indexes below the fill count,
    // since entries are never removed and new ones take the lowest free slot.
    logic [IP_W-1:0]   mem_ip   [TABLE_DEPTH];
    logic [PMAC_W-1:0] mem_pmac [TABLE_DEPTH];

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             idx_reg;
    logic                      pend_reg;
    logic [AW-1:0]             rd_idx_reg;
    logic [IP_W-1:0]           q_ip_reg;
    logic [PMAC_W-1:0]         q_pmac_reg;
    logic                      found_reg;
    logic [AW-1:0]             match_idx_reg;
    logic [PMAC_W-1:0]         match_pmac_reg;

    logic [KIND_W-1:0]         kind_reg;
    logic [IP_W-1:0]           key_ip_reg;
    logic [PMAC_W-1:0]         pmac_reg;
    logic [IP_W-1:0]           src_ip_reg;
    logic [PMAC_W-1:0]         src_pmac_reg;
    logic [SWITCH_ID_BITS-1:0] switch_reg;

    logic                      m_tvalid_reg;
    logic [STAT_W-1:0]         status_reg;
    logic [IP_W-1:0]           res_src_ip_reg;
    logic [PMAC_W-1:0]         res_src_pmac_reg;
    logic [IP_W-1:0]           res_dest_ip_reg;
    logic [PMAC_W-1:0]         res_dest_pmac_reg;
    logic                      flood_reg;
    logic [SWITCH_ID_BITS-1:0] exclude_reg;

    logic                      kind_known;
    logic                      issue;
    logic                      hit;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic                      count_inc;

    assign kind_known = (kind_reg == KIND_REGISTER) || (kind_reg == KIND_ARP);
    assign issue      = cmd.scan && (idx_reg < count_reg);
    assign hit        = pend_reg && (q_ip_reg == key_ip_reg);

    assign sts.scan_done = !kind_known || hit || (!pend_reg && (idx_reg == count_reg));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Input holding register.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg     <= in_kind;
            key_ip_reg   <= in_host_ip;
            pmac_reg     <= in_pmac;
            src_ip_reg   <= in_src_ip;
            src_pmac_reg <= in_src_pmac;
            switch_reg   <= in_from_switch;
        end
    end

    // Scan control: one read is issued per cycle, compared in the cycle after it is issued.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else if (cmd.start) begin
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else if (cmd.scan) begin
            pend_reg <= issue;
            if (issue) begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (hit && !found_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    // Match capture.
    always_ff @(posedge aclk) begin
        if (cmd.scan && hit && !found_reg) begin
            match_idx_reg  <= rd_idx_reg;
            match_pmac_reg <= q_pmac_reg;
        end
    end

    // Table write decision for a registration.
    always_comb begin
        wr_en     = 1'b0;
        count_inc = 1'b0;
        wr_addr   = match_idx_reg;
        if (cmd.finish && (kind_reg == KIND_REGISTER)) begin
            if (found_reg) begin
                wr_en = 1'b1;
            end else if (count_reg < DEPTH_C) begin
                wr_en     = 1'b1;
                count_inc = 1'b1;
                wr_addr   = count_reg[AW-1:0];
            end
        end
    end

    // Memories: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_ip[wr_addr]   <= key_ip_reg;
            mem_pmac[wr_addr] <= pmac_reg;
        end
        if (issue) begin
            q_ip_reg   <= mem_ip[idx_reg[AW-1:0]];
            q_pmac_reg <= mem_pmac[idx_reg[AW-1:0]];
            rd_idx_reg <= idx_reg[AW-1:0];
        end
    end

    // Fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (count_inc) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload; every arm sets every field exactly once.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            case (kind_reg)
                KIND_REGISTER: begin
                    status_reg        <= (found_reg || (count_reg < DEPTH_C)) ?
                                         STAT_REGISTERED : STAT_FULL;
                    res_src_ip_reg    <= '0;
                    res_src_pmac_reg  <= '0;
                    res_dest_ip_reg   <= '0;
                    res_dest_pmac_reg <= '0;
                    flood_reg         <= 1'b0;
                    exclude_reg       <= '0;
                end
                KIND_ARP: begin
                    res_src_ip_reg   <= src_ip_reg;
                    res_src_pmac_reg <= src_pmac_reg;
                    res_dest_ip_reg  <= key_ip_reg;
                    if (found_reg) begin
                        status_reg        <= STAT_HIT;
                        res_dest_pmac_reg <= match_pmac_reg;
                        flood_reg         <= 1'b0;
                        exclude_reg       <= '0;
                    end else begin
                        status_reg        <= STAT_MISS;
                        res_dest_pmac_reg <= BCAST_PMAC;
                        flood_reg         <= 1'b1;
                        exclude_reg       <= switch_reg;
                    end
                end
                default: begin
                    status_reg        <= STAT_UNKNOWN;
                    res_src_ip_reg    <= '0;
                    res_src_pmac_reg  <= '0;
                    res_dest_ip_reg   <= '0;
                    res_dest_pmac_reg <= '0;
                    flood_reg         <= 1'b0;
                    exclude_reg       <= '0;
                end
            endcase
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign out_status    = status_reg;
    assign out_src_ip    = res_src_ip_reg;
    assign out_src_pmac  = res_src_pmac_reg;
    assign out_dest_ip   = res_dest_ip_reg;
    assign out_dest_pmac = res_dest_pmac_reg;
    assign out_flood     = flood_reg;
    assign out_exclude   = exclude_reg;

    // The fill count never passes the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= DEPTH_C)
        else $error("fill count exceeds table depth");

    // The fill count grows by at most one per transaction and never shrinks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + CW'(1)))
        else $error("fill count moved by more than one");

    // A recorded match always points into the filled part of the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> ({1'b0, match_idx_reg} < count_reg))
        else $error("match index outside filled entries");

    // A finished result shows up on the output in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid_reg)
        else $error("finished result not presented");

endmodule

// ----- design/ip_to_pmac_resolution_table.sv -----
// Top level of the IP to pseudo-MAC resolution table with stream ports.
//
//  Channel | Direction | tdata fields (low bit up)                          | tuser
//  s_      | in        | host_ip, pmac_in, src_ip, src_pmac, from_switch    | kind
//  m_      | out       | resp_src_ip, resp_src_pmac, resp_dest_ip,          | status
//          |           | resp_dest_pmac, flood, exclude_switch              |
//
//  A transaction that misses scans every filled entry before its result is built; the
//  scan reads one entry per cycle from the single read port. A match ends the scan at
//  the matching entry. An empty table or an unknown kind ends the scan at once. One
//  transaction is in work at a time; the next is accepted in the cycle after the previous
//  result enters the output register. A stalled result holds the block in its final step
//  until m_tready is seen. Reset clears the fill count but not the table memories; no
//  clearing pass is needed.
module ip_to_pmac_resolution_table import ippmac_pkg::*; #(
    parameter int TABLE_DEPTH    = 64,
    parameter int SWITCH_ID_BITS = 6,
    localparam int IN_BITS  = 2 * IP_W + 2 * PMAC_W + SWITCH_ID_BITS,
    localparam int OUT_BITS = 2 * IP_W + 2 * PMAC_W + 1 + SWITCH_ID_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // host_ip, pmac_in, src_ip, src_pmac, from_switch, zero fill
    input  logic [IN_W-1:0]   s_tdata,
    // kind
    input  logic [KIND_W-1:0] s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // resp_src_ip, resp_src_pmac, resp_dest_ip, resp_dest_pmac, flood,
    // exclude_switch, zero fill
    output logic [OUT_W-1:0]  m_tdata,
    // status
    output logic [STAT_W-1:0] m_tuser
);

    localparam int O_SPMAC = IP_W;
    localparam int O_DIP   = IP_W + PMAC_W;
    localparam int O_DPMAC = 2 * IP_W + PMAC_W;
    localparam int O_SW    = 2 * IP_W + 2 * PMAC_W;

    ippmac_cmd_t               cmd;
    ippmac_sts_t               sts;
    logic [STAT_W-1:0]         out_status;
    logic [IP_W-1:0]           out_src_ip;
    logic [PMAC_W-1:0]         out_src_pmac;
    logic [IP_W-1:0]           out_dest_ip;
    logic [PMAC_W-1:0]         out_dest_pmac;
    logic                      out_flood;
    logic [SWITCH_ID_BITS-1:0] out_exclude;

    ippmac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ippmac_datapath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .SWITCH_ID_BITS (SWITCH_ID_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_kind        (s_tuser),
        .in_host_ip     (s_tdata[O_SPMAC-1:0]),
        .in_pmac        (s_tdata[O_DIP-1:O_SPMAC]),
        .in_src_ip      (s_tdata[O_DPMAC-1:O_DIP]),
        .in_src_pmac    (s_tdata[O_SW-1:O_DPMAC]),
        .in_from_switch (s_tdata[O_SW+SWITCH_ID_BITS-1:O_SW]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_status     (out_status),
        .out_src_ip     (out_src_ip),
        .out_src_pmac   (out_src_pmac),
        .out_dest_ip    (out_dest_ip),
        .out_dest_pmac  (out_dest_pmac),
        .out_flood      (out_flood),
        .out_exclude    (out_exclude)
    );

    // Pack the result transaction; unused high bits stay zero.
    always_comb begin
        m_tdata                                  = '0;
        m_tdata[O_SPMAC-1:0]                     = out_src_ip;
        m_tdata[O_DIP-1:O_SPMAC]                 = out_src_pmac;
        m_tdata[O_DPMAC-1:O_DIP]                 = out_dest_ip;
        m_tdata[O_SW-1:O_DPMAC]                  = out_dest_pmac;
        m_tdata[O_SW]                            = out_flood;
        m_tdata[O_SW+SWITCH_ID_BITS:O_SW+1]      = out_exclude;
        m_tuser                                  = out_status;
    end

endmodule
